// ===== rtl/ufoa_pkg.sv =====
// ============================================================================
// ufoa_pkg: shared types and constants for the union-find OR-aggregate engine
// Node and value sizes, operation codes and memory request bundles.
// ============================================================================
package ufoa_pkg;

  // Port field widths
  localparam int NODE_W  = 10;
  localparam int VALUE_W = 32;
  localparam int OP_W    = 2;

  // Store geometry
  localparam int NODE_COUNT = 1024;
  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int VALUE_BITS = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND  = 2'd1;
  localparam logic [OP_W-1:0] OP_MERGE = 2'd2;

  // Parent store access for one cycle
  typedef struct packed {
    logic                 rd_en;
    logic [NODE_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [NODE_BITS-1:0] wr_addr;
    logic [NODE_BITS-1:0] wr_data;
  } par_req_t;

  // Value store access for one cycle
  typedef struct packed {
    logic                  rd_en;
    logic [NODE_BITS-1:0]  rd_addr;
    logic                  wr_en;
    logic [NODE_BITS-1:0]  wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
  } val_req_t;

endpackage

// ===== rtl/ufoa_store.sv =====
// ============================================================================
// ufoa_store: parent and value memories
// Two single-port-write, single-port-read RAMs with registered read data.
// ============================================================================
module ufoa_store import ufoa_pkg::*; (
  input  logic                  clk,
  input  par_req_t              par_req,
  output logic [NODE_BITS-1:0]  par_rdata,
  input  val_req_t              val_req,
  output logic [VALUE_BITS-1:0] val_rdata
);

  logic [NODE_BITS-1:0]  par_mem [NODE_COUNT];
  logic [VALUE_BITS-1:0] val_mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (par_req.wr_en) begin
      par_mem[par_req.wr_addr] <= par_req.wr_data;
    end
    if (par_req.rd_en) begin
      par_rdata <= par_mem[par_req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (val_req.wr_en) begin
      val_mem[val_req.wr_addr] <= val_req.wr_data;
    end
    if (val_req.rd_en) begin
      val_rdata <= val_mem[val_req.rd_addr];
    end
  end

endmodule

// ===== rtl/union_find_or_aggregate.sv =====
// ============================================================================
// union_find_or_aggregate: disjoint-set engine with OR aggregate per set
// Sequencer around a parent RAM and a value RAM; finds compress their paths.
// ============================================================================
// Disjoint-set engine over 1024 nodes, each holding a 32-bit value word; a
// merge stores the OR of both roots' values at the new root, while a load
// writes only the addressed node. One item is worked at a time; in_ready is
// high only while the sequencer is idle, and the finished result sits in an
// output register so the next item can be taken before it drains. After
// reset a clearing pass writes all 1024 parent entries to identity and all
// value words to zero; in_ready stays low through it. The parent RAM read
// port does one parent lookup per cycle. A load or an unused operation goes
// straight to the output stage; a find walks up to its root, then rewrites
// each node on the path to point at the root, then reads the root's value; a
// merge does both finds back to back, then the value read-modify-write.
// Path compression keeps the walks short on average.
module union_find_or_aggregate import ufoa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    operation,
  input  logic [NODE_W-1:0]  node_a,
  input  logic [NODE_W-1:0]  node_b,
  input  logic [VALUE_W-1:0] load_value,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [NODE_W-1:0]  root_node,
  output logic [VALUE_W-1:0] set_value,
  output logic               already_joined
);

  // Sequencer states
  localparam logic [3:0] ST_CLEAR  = 4'd0;  // post-reset RAM init sweep
  localparam logic [3:0] ST_IDLE   = 4'd1;  // waiting for an input transfer
  localparam logic [3:0] ST_WALK   = 4'd2;  // parent[cur] on read data, climb
  localparam logic [3:0] ST_COMP   = 4'd3;  // parent[cur] on read data, repoint
  localparam logic [3:0] ST_NEXT   = 4'd4;  // one find done, pick next step
  localparam logic [3:0] ST_VAL_A  = 4'd5;  // value of first root arriving
  localparam logic [3:0] ST_UPDATE = 4'd6;  // value of reported root arriving
  localparam logic [3:0] ST_EMIT   = 4'd7;  // hand result to output register

  logic [3:0]            state;
  logic [NODE_BITS-1:0]  clr_idx;
  logic [OP_W-1:0]       op;
  logic [NODE_BITS-1:0]  node_b_q;
  logic [NODE_BITS-1:0]  start;     // first node of the current find
  logic [NODE_BITS-1:0]  cur;       // node whose parent is being read
  logic [NODE_BITS-1:0]  root;      // root of the current find
  logic [NODE_BITS-1:0]  root_a;    // root of node_a on a merge
  logic                  second;    // merge is on its second find
  logic [VALUE_BITS-1:0] val_a;     // first root's value (zero on a find)
  logic [NODE_BITS-1:0]  res_root;
  logic [VALUE_BITS-1:0] res_value;
  logic                  res_joined;

  par_req_t              par_req;
  val_req_t              val_req;
  logic [NODE_BITS-1:0]  par_rdata;
  logic [VALUE_BITS-1:0] val_rdata;
  logic [NODE_BITS-1:0]  in_a;
  logic [VALUE_BITS-1:0] agg;

  assign in_ready = (state == ST_IDLE);
  assign in_a     = node_a[NODE_BITS-1:0];
  assign agg      = val_a | val_rdata;

  ufoa_store u_store (
    .clk       (clk),
    .par_req   (par_req),
    .par_rdata (par_rdata),
    .val_req   (val_req),
    .val_rdata (val_rdata)
  );

  // RAM requests for the current cycle
  always_comb begin
    par_req = '0;
    val_req = '0;
    unique case (state)
      ST_CLEAR: begin
        par_req.wr_en   = 1'b1;
        par_req.wr_addr = clr_idx;
        par_req.wr_data = clr_idx;
        val_req.wr_en   = 1'b1;
        val_req.wr_addr = clr_idx;
        val_req.wr_data = '0;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (operation == OP_LOAD) begin
            val_req.wr_en   = 1'b1;
            val_req.wr_addr = in_a;
            val_req.wr_data = load_value[VALUE_BITS-1:0];
          end else if (operation == OP_FIND || operation == OP_MERGE) begin
            par_req.rd_en   = 1'b1;
            par_req.rd_addr = in_a;
          end
        end
      end
      ST_WALK: begin
        par_req.rd_en = 1'b1;
        if (par_rdata == cur) begin
          // root reached; restart at the first node to rewrite the path
          par_req.rd_en   = (start != cur);
          par_req.rd_addr = start;
        end else begin
          par_req.rd_addr = par_rdata;
        end
      end
      ST_COMP: begin
        par_req.wr_en   = 1'b1;
        par_req.wr_addr = cur;
        par_req.wr_data = root;
        // next node differs from cur, so no read/write collision
        par_req.rd_en   = (par_rdata != root);
        par_req.rd_addr = par_rdata;
      end
      ST_NEXT: begin
        if (op == OP_MERGE && !second) begin
          par_req.rd_en   = 1'b1;
          par_req.rd_addr = node_b_q;
        end else if (op == OP_MERGE) begin
          val_req.rd_en   = 1'b1;
          val_req.rd_addr = root_a;
        end else begin
          val_req.rd_en   = 1'b1;
          val_req.rd_addr = root;
        end
      end
      ST_VAL_A: begin
        val_req.rd_en   = 1'b1;
        val_req.rd_addr = root;
      end
      ST_UPDATE: begin
        if (op == OP_MERGE) begin
          // same-set merge rewrites identical data, which is harmless
          val_req.wr_en   = 1'b1;
          val_req.wr_addr = root;
          val_req.wr_data = agg;
          par_req.wr_en   = 1'b1;
          par_req.wr_addr = root_a;
          par_req.wr_data = root;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      second  <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == NODE_BITS'(NODE_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            op       <= operation;
            node_b_q <= node_b[NODE_BITS-1:0];
            start    <= in_a;
            cur      <= in_a;
            second   <= 1'b0;
            if (operation == OP_FIND || operation == OP_MERGE) begin
              state <= ST_WALK;
            end else begin
              // load and unused codes report all zeros
              res_root   <= '0;
              res_value  <= '0;
              res_joined <= 1'b0;
              state      <= ST_EMIT;
            end
          end
        end
        ST_WALK: begin
          if (par_rdata == cur) begin
            root <= cur;
            cur  <= start;
            state <= (start == cur) ? ST_NEXT : ST_COMP;
          end else begin
            cur <= par_rdata;
          end
        end
        ST_COMP: begin
          cur <= par_rdata;
          if (par_rdata == root) begin
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (op == OP_MERGE && !second) begin
            root_a <= root;
            second <= 1'b1;
            start  <= node_b_q;
            cur    <= node_b_q;
            state  <= ST_WALK;
          end else if (op == OP_MERGE) begin
            state <= ST_VAL_A;
          end else begin
            val_a <= '0;
            state <= ST_UPDATE;
          end
        end
        ST_VAL_A: begin
          val_a <= val_rdata;
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          res_root   <= root;
          res_value  <= agg;
          res_joined <= (op == OP_MERGE) && (root_a == root);
          state      <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && (!out_valid || out_ready)) begin
      root_node      <= NODE_W'(res_root);
      set_value      <= VALUE_W'(res_value);
      already_joined <= res_joined;
    end
  end

endmodule

// ===== rtl/ufoa_checker.sv =====
// ============================================================================
// ufoa_checker: port-level checks for union_find_or_aggregate
// Watches the top-level ports only; attached by bind.
// ============================================================================
module ufoa_checker import ufoa_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [OP_W-1:0]    operation,
  input logic               out_valid,
  input logic               out_ready,
  input logic [NODE_W-1:0]  root_node,
  input logic [VALUE_W-1:0] set_value,
  input logic               already_joined
);

  // clearing pass keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    $past(rst) |-> !in_ready)
    else $error("input open during clearing pass");

  // one item at a time
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after a transfer");

  // load on an empty output reports zeros after the emit state fills the output register
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_LOAD && !out_valid
    |=> ##1 (out_valid && root_node == '0 && set_value == '0 && !already_joined))
    else $error("load result wrong or late");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(root_node)
      && $stable(set_value) && $stable(already_joined))
    else $error("result changed while stalled");

endmodule

bind union_find_or_aggregate ufoa_checker u_ufoa_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .operation      (operation),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .root_node      (root_node),
  .set_value      (set_value),
  .already_joined (already_joined)
);

// ===== tb/sv/union_find_or_aggregate_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// union_find_or_aggregate_test: self-checking bench for the union-find engine
// Drives load, find, merge and spare-code transfers with bursty valid and a stalling
// receiver, tracks the disjoint-set forest and its OR values in the bench, and
// checks every result transfer field by field in order.
// ============================================================================
module union_find_or_aggregate_test;
  import ufoa_pkg::*;

  // Operation code the block does not define: no state change, all-zero result
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // Cycles with no transfer on either channel before the run is abandoned.
  // Worst case is a merge over a 1023-deep chain or the clearing pass after
  // reset; the limit is well above either.
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_OPS = 550;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 150;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [NODE_W-1:0]  a;
    logic [NODE_W-1:0]  b;
    logic [VALUE_W-1:0] v;
  } uf_op_t;

  typedef struct packed {
    logic [NODE_W-1:0]  root;
    logic [VALUE_W-1:0] value;
    logic               joined;
  } uf_answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    operation = '0;
  logic [NODE_W-1:0]  node_a = '0;
  logic [NODE_W-1:0]  node_b = '0;
  logic [VALUE_W-1:0] load_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [NODE_W-1:0]  root_node;
  logic [VALUE_W-1:0] set_value;
  logic               already_joined;

  uf_op_t     op_q[$];      // items waiting for the driver
  uf_answer_t answer_q[$];  // predicted results not yet seen

  // Bench copy of the forest
  logic [NODE_W-1:0]  link_of[NODE_COUNT];
  logic [VALUE_W-1:0] or_of[NODE_COUNT];

  int n_errors = 0;
  int n_results = 0;
  int idle_cycles = 0;

  union_find_or_aggregate DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .node_a(node_a),
    .node_b(node_b),
    .load_value(load_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .root_node(root_node),
    .set_value(set_value),
    .already_joined(already_joined)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Forest tracking
  // --------------------------------------------------------------------------

  // Walk to the root, then point every node on the walked path at it.
  function automatic logic [NODE_W-1:0] trace_root(logic [NODE_W-1:0] start);
    logic [NODE_W-1:0] top;
    logic [NODE_W-1:0] walk;
    logic [NODE_W-1:0] nxt;
    int steps;
    top = start;
    steps = 0;
    while (link_of[top] != top && steps < NODE_COUNT) begin
      top = link_of[top];
      steps++;
    end
    walk = start;
    steps = 0;
    while (walk != top && steps < NODE_COUNT) begin
      nxt = link_of[walk];
      link_of[walk] = top;
      walk = nxt;
      steps++;
    end
    return top;
  endfunction

  // Apply one accepted transfer to the forest and queue the result it owes.
  function automatic void forest_step(uf_op_t item);
    uf_answer_t ans;
    logic [NODE_W-1:0] ra;
    logic [NODE_W-1:0] rb;
    ans = '0;
    case (item.op)
      OP_LOAD: begin
        // written at the node only; a non-root load leaves its root's OR alone
        or_of[item.a] = item.v;
      end
      OP_FIND: begin
        ans.root = trace_root(item.a);
        ans.value = or_of[ans.root];
      end
      OP_MERGE: begin
        ra = trace_root(item.a);
        rb = trace_root(item.b);
        ans.joined = (ra == rb);
        or_of[rb] = or_of[rb] | or_of[ra];
        link_of[ra] = rb;
        ans.root = rb;
        ans.value = or_of[rb];
      end
      default: ;  // spare code: nothing changes, zero result
    endcase
    answer_q.push_back(ans);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void queue_op(logic [OP_W-1:0] op, logic [NODE_W-1:0] a,
                                   logic [NODE_W-1:0] b, logic [VALUE_W-1:0] v);
    uf_op_t item;
    item.op = op;
    item.a = a;
    item.b = b;
    item.v = v;
    op_q.push_back(item);
  endfunction

  // Sparse words make the OR aggregation visible; dense ones hit every bit.
  function automatic logic [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
    if (sel < 8) return $urandom;
    if (sel == 8) return '1;
    return '0;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts of transfers with random gaps between them
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : driver
    uf_op_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        forest_step({operation, node_a, node_b, load_value});
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0 || op_q.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          nxt = op_q.pop_front();
          operation <= nxt.op;
          node_a <= nxt.a;
          node_b <= nxt.b;
          load_value <= nxt.v;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: a stall pattern redrawn each time mode_age wraps, plus one long
  // hold-off so the output register fills and the input side backs up.
  // --------------------------------------------------------------------------
  int ready_mode = 0;
  int mode_age = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && n_results >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      mode_age++;
      if (mode_age >= 64) begin
        mode_age = 0;
        ready_mode = $urandom_range(0, 2);
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every result transfer against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    uf_answer_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (answer_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result: expected none, %s %0d value %h joined %0b",
                 $time, "actual root", root_node, set_value, already_joined);
      end else begin
        want = answer_q.pop_front();
        if (root_node !== want.root || set_value !== want.value ||
            already_joined !== want.joined) begin
          n_errors++;
          $display("%0t: mismatch: expected root %0d value %h joined %0b,",
                   $time, want.root, want.value, want.joined,
                   " actual root %0d value %h joined %0b",
                   root_node, set_value, already_joined);
        end
      end
    end
  end

  // Watchdog: only cycles with no transfer on either side count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("union_find_or_aggregate test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: fill the stimulus queue, release reset, wait for the drain
  // --------------------------------------------------------------------------
  initial begin
    int k;
    int len;
    int pick;
    int n_rand;
    int pool_age;
    logic [NODE_W-1:0] base;
    logic [NODE_W-1:0] pool_base;
    logic [NODE_W-1:0] na;
    logic [NODE_W-1:0] nb;

    for (k = 0; k < NODE_COUNT; k++) begin
      link_of[k] = NODE_W'(k);
      or_of[k] = '0;
    end

    // Directed: extremes, every code, non-root load, self-merge, a deep walk
    queue_op(OP_LOAD, 10'd0, 10'd1023, 32'hFFFF_FFFF);
    queue_op(OP_LOAD, 10'd1023, 10'd0, 32'h8000_0001);
    queue_op(OP_FIND, 10'd0, 10'd1023, 32'h0);
    queue_op(OP_FIND, 10'd1023, 10'd0, 32'hFFFF_FFFF);
    queue_op(OP_MERGE, 10'd0, 10'd1023, 32'h0);
    queue_op(OP_MERGE, 10'd1023, 10'd0, 32'hFFFF_FFFF);  // same set
    queue_op(OP_SPARE, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
    queue_op(OP_LOAD, 10'd0, 10'd0, 32'h0000_0005);      // 0 is no longer a root
    queue_op(OP_FIND, 10'd0, 10'd0, 32'h0);
    for (k = 2; k < 10; k++) begin
      queue_op(OP_MERGE, NODE_W'(k), NODE_W'(k + 1), VALUE_W'(k));
    end
    queue_op(OP_FIND, 10'd2, 10'd0, 32'h0);   // walks the whole chain
    queue_op(OP_FIND, 10'd2, 10'd0, 32'h0);   // now one hop after compression
    queue_op(OP_MERGE, 10'd5, 10'd5, 32'h0);  // node merged with itself
    queue_op(OP_SPARE, 10'd0, 10'd0, 32'h0);

    // Random: mostly ops over a small drifting pool so sets actually grow,
    // with occasional chain builds and some full-range noise
    n_rand = 0;
    pool_age = 0;
    pool_base = NODE_W'($urandom);
    while (n_rand < RANDOM_OPS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        len = $urandom_range(4, 40);
        base = NODE_W'($urandom);
        for (k = 0; k < len; k++) begin
          queue_op(OP_MERGE, base + NODE_W'(k), base + NODE_W'(k + 1), $urandom);
        end
        queue_op(OP_FIND, base, NODE_W'($urandom), $urandom);
        n_rand += len + 1;
      end else begin
        if (pool_age >= 60) begin
          pool_age = 0;
          pool_base = NODE_W'($urandom);
        end
        pool_age++;
        na = ($urandom_range(0, 99) < 85) ? pool_base + NODE_W'($urandom_range(0, 31))
                                          : NODE_W'($urandom);
        nb = ($urandom_range(0, 99) < 85) ? pool_base + NODE_W'($urandom_range(0, 31))
                                          : NODE_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25) queue_op(OP_LOAD, na, nb, pick_value());
        else if (pick < 60) queue_op(OP_FIND, na, nb, $urandom);
        else if (pick < 95) queue_op(OP_MERGE, na, nb, $urandom);
        else queue_op(OP_SPARE, na, nb, $urandom);
        n_rand++;
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (op_q.size() != 0 || in_valid || answer_q.size() != 0) @(negedge clk);
    // keep watching for stray results after the last expected one
    repeat (40) @(posedge clk);

    if (n_errors == 0) begin
      $display("union_find_or_aggregate test passed");
    end else begin
      $display("union_find_or_aggregate test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ufoa_pkg.sv
rtl/ufoa_store.sv
rtl/union_find_or_aggregate.sv
rtl/ufoa_checker.sv
tb/sv/union_find_or_aggregate_test.sv
